// ===== design/psu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the scanline unfilter
// Filter codes, register indexes, field widths and the queue item layout.
// ----------------------------------------------------------------------------
package psu_pkg;

  // register field widths
  localparam int ROW_LEN_W  = 14;
  localparam int STRIDE_W   = 4;
  localparam int ROWS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // default sizing of the line store and pixel history
  localparam int DEF_MAX_ROW_BYTES   = 8192;
  localparam int DEF_MAX_PIXEL_BYTES = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 2'd2;

  // largest legal filter type
  localparam logic [7:0] FILTER_TYPE_MAX = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filter_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_err;   // error result for a bad filter type
    logic        a_ok;     // left neighbor exists
    logic        row_nz;   // row above exists
    psu_filter_t filter;
    logic        last_col;
    logic        last_row;
    logic [7:0]  data;
  } psu_item_t;

endpackage
`default_nettype wire

// ===== design/psu_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_in_if: filtered byte stream channel
// Valid/ready channel carrying one filtered byte per transfer.
// ----------------------------------------------------------------------------
interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;

  modport source (output valid, output filtered_byte, input ready);
  modport sink   (input valid, input filtered_byte, output ready);
endinterface
`default_nettype wire

// ===== design/psu_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_out_if: reconstructed byte channel
// Valid/ready channel carrying one rebuilt byte and its marks per transfer.
// ----------------------------------------------------------------------------
interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_last;
  logic       image_last;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output row_last,
                  output image_last, output bad_filter, input ready);
  modport sink   (input valid, input pixel_byte, input row_last,
                  input image_last, input bad_filter, output ready);
endinterface
`default_nettype wire

// ===== design/psu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_front: byte classifier and position tracking
// Holds the registers, latches filter types, tracks column and row, and
// pushes one classified item per result into the queue.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  psu_in_if.sink                in_ch,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  input  wire                   q_full,
  output logic                  q_push,
  output psu_item_t             q_item,
  output logic [AW-1:0]         q_addr,
  output logic [HW-1:0]         q_wslot,
  output logic [HW-1:0]         q_rslot
);

  localparam int CW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int LW   = (CW > ROW_LEN_W) ? CW : ROW_LEN_W;
  localparam int SUMW = HW + 2;

  logic [ROW_LEN_W-1:0] row_length_r;
  logic [STRIDE_W-1:0]  pixel_stride_r;
  logic [ROWS_W-1:0]    image_rows_r;

  logic [LW-1:0]     col_r, col_nxt;
  logic [HW-1:0]     xmod_r, xmod_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  psu_filter_t       filter_r, filter_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic              failed_r, failed_nxt;

  logic              accept;
  logic [LW-1:0]     len_ext, eff_len;
  logic [ROWS_W-1:0] eff_rows;
  logic [STRIDE_W-1:0] eff_s;
  logic              last_col, last_row;
  logic [SUMW-1:0]   slot_sum;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r   <= ROW_LEN_W'(1);
      pixel_stride_r <= STRIDE_W'(1);
      image_rows_r   <= ROWS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH:   row_length_r   <= cfg_data[ROW_LEN_W-1:0];
        CFG_PIXEL_STRIDE: pixel_stride_r <= cfg_data[STRIDE_W-1:0];
        CFG_IMAGE_ROWS:   image_rows_r   <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the registers into their working ranges
  always_comb begin
    len_ext = LW'(row_length_r);
    if (len_ext == '0)
      eff_len = LW'(1);
    else if (len_ext > LW'(MAX_ROW_BYTES))
      eff_len = LW'(MAX_ROW_BYTES);
    else
      eff_len = len_ext;

    eff_rows = (image_rows_r == '0) ? ROWS_W'(1) : image_rows_r;

    if (pixel_stride_r == '0)
      eff_s = STRIDE_W'(1);
    else if (pixel_stride_r > STRIDE_W'(MAX_PIXEL_BYTES))
      eff_s = STRIDE_W'(MAX_PIXEL_BYTES);
    else
      eff_s = pixel_stride_r;
  end

  assign last_col = ({1'b0, col_r} + (LW+1)'(1)) >= {1'b0, eff_len};
  assign last_row = ({1'b0, row_r} + (ROWS_W+1)'(1)) >= {1'b0, eff_rows};

  // history slot of the left neighbor, kept below the history depth
  assign slot_sum = SUMW'(xmod_r) + SUMW'(MAX_PIXEL_BYTES) - SUMW'(eff_s);
  assign q_rslot  = (slot_sum >= SUMW'(MAX_PIXEL_BYTES)) ?
                    HW'(slot_sum - SUMW'(MAX_PIXEL_BYTES)) : HW'(slot_sum);
  assign q_wslot  = xmod_r;
  assign q_addr   = col_r[AW-1:0];

  // classification and position update
  always_comb begin
    col_nxt      = col_r;
    xmod_nxt     = xmod_r;
    row_nxt      = row_r;
    filter_nxt   = filter_r;
    awaiting_nxt = awaiting_r;
    failed_nxt   = failed_r;
    q_push       = 1'b0;

    q_item          = '0;
    q_item.a_ok     = col_r >= LW'(eff_s);
    q_item.row_nz   = row_r != '0;
    q_item.filter   = filter_r;
    q_item.last_col = last_col;
    q_item.last_row = last_row;
    q_item.data     = in_ch.filtered_byte;

    if (accept) begin
      if (awaiting_r) begin
        awaiting_nxt = 1'b0;
        col_nxt      = '0;
        xmod_nxt     = '0;
        if (!failed_r) begin
          if (in_ch.filtered_byte > FILTER_TYPE_MAX) begin
            failed_nxt    = 1'b1;
            q_push        = 1'b1;
            q_item        = '0;
            q_item.is_err = 1'b1;
          end else begin
            filter_nxt = psu_filter_t'(in_ch.filtered_byte[2:0]);
          end
        end
      end else begin
        q_push = !failed_r;
        if (last_col) begin
          col_nxt      = '0;
          xmod_nxt     = '0;
          awaiting_nxt = 1'b1;
          if (last_row) begin
            row_nxt    = '0;
            failed_nxt = 1'b0;
          end else begin
            row_nxt = row_r + ROWS_W'(1);
          end
        end else begin
          col_nxt  = col_r + LW'(1);
          xmod_nxt = (xmod_r == HW'(MAX_PIXEL_BYTES - 1)) ? '0 : xmod_r + HW'(1);
        end
      end
    end
  end

  // position and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      xmod_r     <= '0;
      row_r      <= '0;
      filter_r   <= FILT_NONE;
      awaiting_r <= 1'b1;
      failed_r   <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      xmod_r     <= xmod_nxt;
      row_r      <= row_nxt;
      filter_r   <= filter_nxt;
      awaiting_r <= awaiting_nxt;
      failed_r   <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/psu_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_fifo: item queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module psu_fifo import psu_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  input  wire              pop,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;

  assign full     = cnt_r == NW'(DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = mem_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push)
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (pop)
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (push && !pop)
      cnt_nxt = cnt_r + NW'(1);
    else if (pop && !push)
      cnt_nxt = cnt_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== design/psu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_back: reconstruction datapath
// Reads the line store, rebuilds each byte from its neighbors, updates the
// line store and pixel histories, and holds the result in an output register.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  input  psu_item_t        q_item,
  input  wire [AW-1:0]     q_addr,
  input  wire [HW-1:0]     q_wslot,
  input  wire [HW-1:0]     q_rslot,
  output logic             q_pop,
  psu_out_if.source        out_ch
);

  // line store and pixel histories
  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] left_r   [MAX_PIXEL_BYTES];
  logic [7:0] ul_r     [MAX_PIXEL_BYTES];

  // work stage
  logic            b1_valid_r, b1_valid_nxt;
  psu_item_t       item_r;
  logic [AW-1:0]   addr_r;
  logic [HW-1:0]   wslot_r;
  logic [HW-1:0]   rslot_r;
  logic [7:0]      ram_q_r;
  logic            fwd_r;
  logic [7:0]      fwd_val_r;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r;
  logic            out_row_last_r;
  logic            out_image_last_r;
  logic            out_bad_r;

  logic            adv;
  logic            fwd_hit;
  logic [7:0]      a, b, c, pred, val;
  logic [8:0]      ab_sum;

  function automatic logic [7:0] paeth(input logic [7:0] pa, input logic [7:0] pb,
                                       input logic [7:0] pc);
    logic signed [10:0] p, da, db, dc;
    begin
      p  = $signed({3'b000, pa}) + $signed({3'b000, pb}) - $signed({3'b000, pc});
      da = p - $signed({3'b000, pa});
      db = p - $signed({3'b000, pb});
      dc = p - $signed({3'b000, pc});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc)
        paeth = pa;
      else if (db <= dc)
        paeth = pb;
      else
        paeth = pc;
    end
  endfunction

  // stage handshake
  assign adv           = b1_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop         = q_valid && (!b1_valid_r || adv);
  assign b1_valid_nxt  = q_pop ? 1'b1 : (adv ? 1'b0 : b1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // same address written by the leaving item while the next one reads it
  assign fwd_hit = adv && !item_r.is_err && (q_addr == addr_r);

  // neighbors and prediction
  always_comb begin
    a      = item_r.a_ok ? left_r[rslot_r] : 8'd0;
    b      = item_r.row_nz ? (fwd_r ? fwd_val_r : ram_q_r) : 8'd0;
    c      = (item_r.row_nz && item_r.a_ok) ? ul_r[rslot_r] : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    unique case (item_r.filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    val = item_r.data + pred;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_valid_r  <= b1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the work stage and read the line store
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r    <= q_item;
      addr_r    <= q_addr;
      wslot_r   <= q_wslot;
      rslot_r   <= q_rslot;
      ram_q_r   <= line_mem[q_addr];
      fwd_r     <= fwd_hit;
      fwd_val_r <= val;
    end
  end

  // write back the rebuilt byte
  always_ff @(posedge clk) begin
    if (adv && !item_r.is_err) begin
      line_mem[addr_r] <= val;
      left_r[wslot_r]  <= val;
      ul_r[wslot_r]    <= b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r       <= item_r.is_err ? 8'd0 : val;
      out_row_last_r   <= !item_r.is_err && item_r.last_col;
      out_image_last_r <= !item_r.is_err && item_r.last_col && item_r.last_row;
      out_bad_r        <= item_r.is_err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = out_byte_r;
  assign out_ch.row_last   = out_row_last_r;
  assign out_ch.image_last = out_image_last_r;
  assign out_ch.bad_filter = out_bad_r;

endmodule
`default_nettype wire

// ===== design/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG scanline reconstruction
// Rebuilds raw bytes from an inflated, filtered PNG stream.
//
// in_ch takes one filtered byte per transfer; each row opens with its filter
// type byte, which gives no result. out_ch delivers one rebuilt byte per data
// byte with row_last and image_last marks; a filter type above four gives one
// result with bad_filter set and the rest of that image gives nothing.
// Registers are written through cfg_we/cfg_index/cfg_data; write them only
// while idle: the block itself does not enforce this. Throughput is one byte
// per cycle while out_ch is ready and the queue is not full. Each result goes
// via a four-entry queue between classifier and datapath, the work stage
// that reads the line store and rebuilds the byte, and an output register,
// so input transfers go on while out_ch is stalled until the queue fills.
// Reset (rst_n low at a clock edge) sets all registers to one, expects a
// filter byte next and empties the queue and output; the line store has no
// clearing pass and is read only where the previous row wrote it.
// ----------------------------------------------------------------------------
module png_scanline_unfilter import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
  input  wire                  clk,
  input  wire                  rst_n,
  psu_in_if.sink               in_ch,
  psu_out_if.source            out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int QW = $bits(psu_item_t) + AW + 2 * HW;

  logic            q_full, q_push, q_pop, q_valid;
  psu_item_t       f_item, b_item;
  logic [AW-1:0]   f_addr, b_addr;
  logic [HW-1:0]   f_wslot, f_rslot, b_wslot, b_rslot;
  logic [QW-1:0]   q_in, q_out;

  // classifier
  psu_front #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item),
    .q_addr    (f_addr),
    .q_wslot   (f_wslot),
    .q_rslot   (f_rslot)
  );

  // queue between classifier and datapath
  assign q_in = {f_item, f_addr, f_wslot, f_rslot};

  psu_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  assign {b_item, b_addr, b_wslot, b_rslot} = q_out;

  // datapath
  psu_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (b_item),
    .q_addr  (b_addr),
    .q_wslot (b_wslot),
    .q_rslot (b_rslot),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // checks
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_error_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_filter) |->
      (out_ch.pixel_byte == 8'd0 && !out_ch.row_last && !out_ch.image_last))
    else $error("error result carries data or marks");

  a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.image_last) |-> out_ch.row_last)
    else $error("image end without row end");

endmodule
`default_nettype wire
